FILE: rtl/led_matrix_scan_pwm_defines.svh
// ---------------------------------------------------------------------------
// LED matrix scan driver assertion macros
// Concurrent check wrappers that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_PWM_DEFINES_SVH
`define LED_MATRIX_SCAN_PWM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset
`define LMSP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, held off during reset
`define LMSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LMSP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define LMSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/lmsp_pkg.sv
// ---------------------------------------------------------------------------
// LED matrix scan driver package
// Shared constants, operation codes, register indexes and state encoding.
// ---------------------------------------------------------------------------
package lmsp_pkg;

  // Default geometry
  localparam int ROWS_DEF       = 8;
  localparam int COLUMNS_DEF    = 8;
  localparam int LINE_BYTES_DEF = 4;

  // Colors per pixel and bits per line byte
  localparam int COLORS    = 3;
  localparam int BYTE_BITS = 8;

  // Field and register widths
  localparam int DEPTH_W   = 8;
  localparam int OFFSET_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int PIX_POS_W = 3;
  localparam int COMP_W    = 8;
  localparam int BIDX_W    = 6;
  localparam int SROW_W    = 3;
  localparam int POS_CMP_W = 11;

  // Register reset values
  localparam logic [DEPTH_W-1:0]  COLOR_DEPTH_RST = 8'd8;
  localparam logic [OFFSET_W-1:0] COL_OFFSET_RST  = 9'd0;
  localparam logic [OFFSET_W-1:0] ROW_OFFSET_RST  = 9'd24;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SWAP  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_DEPTH = 2'd0,
    CFG_COL_OFFSET  = 2'd1,
    CFG_ROW_OFFSET  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } scan_state_t;

endpackage

FILE: rtl/led_matrix_scan_pwm.sv
// ---------------------------------------------------------------------------
// LED matrix scan driver with PWM and double-buffered frame store
// Bit-serial subframe builder feeding a byte-wide shift-line stream.
// ---------------------------------------------------------------------------
// Input stream (s_*): tuser carries the operation, tdata the pixel. A pixel
// write goes to the back frame, a swap request arms the pending flag, and a
// tick emits one subframe. Other operation codes are taken and ignored.
// Output stream (m_*): one transaction per shift-line byte, byte index 0
// first, tlast on the final byte where the line is latched.
// A tick walks the line one bit per cycle while the output is not stalled,
// with one frame-store read and one compare per bit, and keeps the input
// closed until the last byte of the line is loaded into the output register.
// Each byte is loaded once its eight bits are shifted in. After the last
// depth step of the last row a pending swap exchanges the frames.
// A single output register parts the two sides: the next item is taken while
// the last byte of a subframe still waits. While the receiver stalls with a
// byte held, the bit walk freezes in place.
// Reset (rst, synchronous) clears both frames to black through per-entry valid bits,
// selects frame zero, drops the swap request, and returns the scan to row 0, depth
// step 1 and the register defaults. Configuration is written through cfg_wr_en /
// cfg_index / cfg_wr_data, by the user only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`include "led_matrix_scan_pwm_defines.svh"

module led_matrix_scan_pwm #(
  parameter int ROWS       = lmsp_pkg::ROWS_DEF,
  parameter int COLUMNS    = lmsp_pkg::COLUMNS_DEF,
  parameter int LINE_BYTES = lmsp_pkg::LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic                           cfg_wr_en,
  input  logic [lmsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmsp_pkg::CFG_DAT_W-1:0] cfg_wr_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_row[2:0], pixel_column[5:3], pixel_red[13:6],
                                 // pixel_green[21:14], pixel_blue[29:22], zero[31:30]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // line_byte[7:0], byte_index[13:8], scan_row[16:14],
                                 // depth_step[24:17], swap_pending[25], zero[31:26]
  output logic        m_tlast    // last_of_line
);

  localparam int PIXELS    = ROWS * COLUMNS;
  localparam int ENTRIES   = 2 * PIXELS;
  localparam int AW        = $clog2(ENTRIES);
  localparam int LINE_BITS = lmsp_pkg::BYTE_BITS * LINE_BYTES;
  localparam int PW        = $clog2(LINE_BITS + 1);
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CCW       = $clog2(COLUMNS + 1);
  localparam int BW        = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int DW        = lmsp_pkg::DEPTH_W;
  localparam int OW        = lmsp_pkg::OFFSET_W;
  localparam int CW        = lmsp_pkg::COMP_W;
  localparam int XW        = lmsp_pkg::POS_CMP_W;
  localparam int PXW       = lmsp_pkg::COLORS * CW;

  // Configuration registers
  logic [DW-1:0] color_depth;
  logic [OW-1:0] column_bit_offset;
  logic [OW-1:0] row_bit_offset;

  // Scan state
  lmsp_pkg::scan_state_t state, state_next;
  logic          front_select;
  logic          swap_flag;
  logic [RW-1:0] row_counter;
  logic [DW-1:0] depth_counter;

  // Frame store and per-entry valid bits
  logic [PXW-1:0]     frame_mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;

  // Bit walk, issue side
  logic [PW-1:0]  pos;
  logic [CCW-1:0] col_cnt;
  logic [1:0]     k_cnt;
  logic           scan_issue;
  logic           issue;
  logic           advance;
  logic           color_hit;
  logic           sel_hit;
  logic [AW-1:0]  rd_addr;

  // Bit walk, compare side
  logic           s1_valid;
  logic           s1_color;
  logic           s1_sel;
  logic [1:0]     s1_k;
  logic [PXW-1:0] rd_data;
  logic           rd_valid;
  logic [CW-1:0]  comp;
  logic           line_bit;
  logic [7:0]     byte_sr;
  logic [2:0]     bit_cnt;
  logic [BW-1:0]  byte_cnt;
  logic           byte_done;
  logic           last_byte;
  logic           tick_end;

  // Input decode
  logic          in_xact;
  logic [2:0]    px_row;
  logic [2:0]    px_col;
  logic          px_in_range;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] depth_limit;

  // Output register fields
  logic [7:0]                    out_byte;
  logic [lmsp_pkg::BIDX_W-1:0]   out_index;
  logic [lmsp_pkg::SROW_W-1:0]   out_row;
  logic [DW-1:0]                 out_depth;
  logic                          out_swap;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color_depth       <= lmsp_pkg::COLOR_DEPTH_RST;
      column_bit_offset <= lmsp_pkg::COL_OFFSET_RST;
      row_bit_offset    <= lmsp_pkg::ROW_OFFSET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lmsp_pkg::CFG_COLOR_DEPTH: color_depth       <= cfg_wr_data[DW-1:0];
        lmsp_pkg::CFG_COL_OFFSET:  column_bit_offset <= cfg_wr_data[OW-1:0];
        lmsp_pkg::CFG_ROW_OFFSET:  row_bit_offset    <= cfg_wr_data[OW-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lmsp_pkg::ST_IDLE: begin
        if (in_xact && s_tuser == lmsp_pkg::OP_TICK) state_next = lmsp_pkg::ST_SCAN;
      end
      lmsp_pkg::ST_SCAN: begin
        if (tick_end) state_next = lmsp_pkg::ST_IDLE;
      end
      default: state_next = lmsp_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready   = 1'b0;
    scan_issue = 1'b0;
    unique case (state)
      lmsp_pkg::ST_IDLE: s_tready = 1'b1;
      lmsp_pkg::ST_SCAN: scan_issue = (pos < PW'(LINE_BITS));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lmsp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Decode the input transaction
  assign in_xact     = s_tvalid && s_tready;
  assign px_row      = s_tdata[2:0];
  assign px_col      = s_tdata[5:3];
  assign px_in_range = (int'(px_row) < ROWS) && (int'(px_col) < COLUMNS);
  assign wr_addr     = AW'((front_select ? 0 : PIXELS) + int'(px_row) * COLUMNS
                           + int'(px_col));
  assign depth_limit = (color_depth == '0) ? DW'(1) : color_depth;

  // Write pixels into the back frame
  always_ff @(posedge clk) begin
    if (in_xact && s_tuser == lmsp_pkg::OP_WRITE && px_in_range) begin
      frame_mem[wr_addr] <= {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (in_xact && s_tuser == lmsp_pkg::OP_WRITE && px_in_range) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Hold the walk while a finished byte waits at the output
  assign advance = !m_tvalid || m_tready;
  assign issue   = scan_issue && advance;

  // Locate the current line bit: colour field or row select
  assign color_hit = (XW'(pos) >= XW'(column_bit_offset)) && (int'(col_cnt) < COLUMNS);
  assign sel_hit   = (XW'(pos) == XW'(row_bit_offset) + XW'(row_counter));
  assign rd_addr   = AW'((front_select ? PIXELS : 0) + int'(row_counter) * COLUMNS
                         + (color_hit ? int'(col_cnt) : 0));

  // Advance position and column/colour counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
    end else if (in_xact && s_tuser == lmsp_pkg::OP_TICK) begin
      pos     <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
    end else if (issue) begin
      pos <= pos + PW'(1);
      if (color_hit) begin
        if (k_cnt == 2'(lmsp_pkg::COLORS - 1)) begin
          k_cnt   <= '0;
          col_cnt <= col_cnt + CCW'(1);
        end else begin
          k_cnt <= k_cnt + 2'd1;
        end
      end
    end
  end

  // Read the frame store, registered
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data  <= frame_mem[rd_addr];
      rd_valid <= entry_valid[rd_addr];
      s1_color <= color_hit;
      s1_sel   <= sel_hit;
      s1_k     <= k_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)          s1_valid <= 1'b0;
    else if (advance) s1_valid <= issue;
  end

  // Pick the component and compare against the depth step
  always_comb begin
    case (s1_k)
      2'd0:    comp = rd_data[3*CW-1:2*CW];
      2'd1:    comp = rd_data[2*CW-1:CW];
      default: comp = rd_data[CW-1:0];
    endcase
    if (!rd_valid) comp = '0;
  end

  assign line_bit  = s1_color ? (comp >= depth_counter) : s1_sel;
  assign byte_done = s1_valid && advance && (bit_cnt == 3'd7);
  assign last_byte = (byte_cnt == BW'(LINE_BYTES - 1));
  assign tick_end  = byte_done && last_byte;

  // Shift bits into the byte, lowest line bit first
  always_ff @(posedge clk) begin
    if (s1_valid && advance) byte_sr <= {line_bit, byte_sr[7:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt  <= '0;
      byte_cnt <= '0;
    end else if (in_xact && s_tuser == lmsp_pkg::OP_TICK) begin
      bit_cnt  <= '0;
      byte_cnt <= '0;
    end else if (s1_valid && advance) begin
      bit_cnt <= bit_cnt + 3'd1;
      if (byte_done) byte_cnt <= byte_cnt + BW'(1);
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (rst)            m_tvalid <= 1'b0;
    else if (byte_done) m_tvalid <= 1'b1;
    else if (m_tready)  m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (byte_done) begin
      out_byte  <= {line_bit, byte_sr[7:1]};
      out_index <= lmsp_pkg::BIDX_W'(byte_cnt);
      out_row   <= lmsp_pkg::SROW_W'(row_counter);
      out_depth <= depth_counter;
      out_swap  <= swap_flag;
      m_tlast   <= last_byte;
    end
  end

  assign m_tdata = {6'd0, out_swap, out_depth, out_row, out_index, out_byte};

  // Step depth and row at the end of a subframe; swap frames after a full scan if a swap is pending
  always_ff @(posedge clk) begin
    if (rst) begin
      front_select  <= 1'b0;
      swap_flag     <= 1'b0;
      row_counter   <= '0;
      depth_counter <= DW'(1);
    end else if (in_xact && s_tuser == lmsp_pkg::OP_SWAP) begin
      swap_flag <= 1'b1;
    end else if (tick_end) begin
      if (depth_counter >= depth_limit) begin
        depth_counter <= DW'(1);
        if (row_counter == RW'(ROWS - 1)) begin
          row_counter <= '0;
          if (swap_flag) begin
            front_select <= ~front_select;
            swap_flag    <= 1'b0;
          end
        end else begin
          row_counter <= row_counter + RW'(1);
        end
      end else begin
        depth_counter <= depth_counter + DW'(1);
      end
    end
  end

  // Checks
  `LMSP_ASSERT_IMPLY(a_s1_in_scan, clk, rst, s1_valid, state == lmsp_pkg::ST_SCAN, "bit stage active outside scan")
  `LMSP_ASSERT_IMPLY(a_depth_nonzero, clk, rst, 1'b1, depth_counter != '0, "depth step reached zero")
  `LMSP_ASSERT_NEXT(a_tick_end_idle, clk, rst, tick_end, state == lmsp_pkg::ST_IDLE && m_tvalid && m_tlast, "subframe end did not return to idle with tlast")

endmodule

FILE: tb/sv/tb_led_matrix_scan_pwm.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LED matrix scan driver testbench
// Streams pixel writes, swap requests and subframe ticks into the scan driver
// under random idling and a long output stall, mirrors the double-buffered
// frame and the row/depth scan in a local predictor, and checks every
// shift-line byte against the predicted line.
// ---------------------------------------------------------------------------
module tb_led_matrix_scan_pwm;

  localparam int ROWS         = lmsp_pkg::ROWS_DEF;
  localparam int COLUMNS      = lmsp_pkg::COLUMNS_DEF;
  localparam int LINE_BYTES   = lmsp_pkg::LINE_BYTES_DEF;
  localparam int LINE_BITS    = LINE_BYTES * lmsp_pkg::BYTE_BITS;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  // Operation code that the block leaves unused
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  // Padding bits above the pixel fields stay zero
  localparam logic [31:0] PAD_MASK  = 32'h3FFF_FFFF;

  typedef struct packed {
    logic [7:0] line_byte;
    logic [5:0] byte_index;
    logic [2:0] scan_row;
    logic [7:0] depth_step;
    logic       last_of_line;
    logic       swap_pending;
  } line_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_wr_en   = 1'b0;
  logic [lmsp_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [lmsp_pkg::CFG_DAT_W-1:0] cfg_wr_data = '0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // pixel_row[2:0], pixel_column[5:3], pixel_red[13:6],
                               // pixel_green[21:14], pixel_blue[29:22], zero[31:30]
  logic [1:0]  s_tuser  = '0;  // operation[1:0]

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // line_byte[7:0], byte_index[13:8], scan_row[16:14],
                               // depth_step[24:17], swap_pending[25], zero[31:26]
  logic        m_tlast;        // last_of_line

  // Predicted scan state and register copies
  logic [23:0]                   pixel_mem [0:2*ROWS*COLUMNS-1];
  logic                          front_sel;
  logic                          swap_flag;
  logic [2:0]                    scan_row_ctr;
  logic [7:0]                    depth_ctr;
  logic [lmsp_pkg::DEPTH_W-1:0]  cfg_depth;
  logic [lmsp_pkg::OFFSET_W-1:0] cfg_col_off;
  logic [lmsp_pkg::OFFSET_W-1:0] cfg_row_off;

  line_byte_t  expected_bytes[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  led_matrix_scan_pwm #(
    .ROWS       (ROWS),
    .COLUMNS    (COLUMNS),
    .LINE_BYTES (LINE_BYTES)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  // Free-running clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void log_failure(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
  endfunction

  function automatic string fmt_line_byte(line_byte_t b);
    return $sformatf("byte=%02h idx=%0d row=%0d depth=%0d last=%0b swap=%0b",
                     b.line_byte, b.byte_index, b.scan_row, b.depth_step,
                     b.last_of_line, b.swap_pending);
  endfunction

  // Reset state of the predictor
  function automatic void reset_scan_state();
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    front_sel    = 1'b0;
    swap_flag    = 1'b0;
    scan_row_ctr = '0;
    depth_ctr    = 8'd1;
    cfg_depth    = lmsp_pkg::COLOR_DEPTH_RST;
    cfg_col_off  = lmsp_pkg::COL_OFFSET_RST;
    cfg_row_off  = lmsp_pkg::ROW_OFFSET_RST;
  endfunction

  // Apply one accepted input transaction and queue the line bytes it produces
  function automatic void apply_scan_item(logic [1:0] op, logic [31:0] data);
    logic [LINE_BITS-1:0] line;
    logic [23:0]          px;
    logic [7:0]           comp;
    logic [7:0]           limit;
    line_byte_t           rec;
    int                   pos;
    int                   base;
    case (op)
      lmsp_pkg::OP_WRITE: begin
        pixel_mem[(front_sel ? 0 : ROWS*COLUMNS) + data[2:0]*COLUMNS + data[5:3]] =
          {data[13:6], data[21:14], data[29:22]};
      end
      lmsp_pkg::OP_SWAP: begin
        swap_flag = 1'b1;
      end
      lmsp_pkg::OP_TICK: begin
        line = '0;
        pos = int'(cfg_row_off) + int'(scan_row_ctr);
        if (pos < LINE_BITS) line[pos] = 1'b1;
        // Colour bits override the select bit and earlier colours
        base = (front_sel ? ROWS*COLUMNS : 0) + int'(scan_row_ctr) * COLUMNS;
        for (int c = 0; c < COLUMNS; c++) begin
          px = pixel_mem[base + c];
          for (int k = 0; k < lmsp_pkg::COLORS; k++) begin
            comp = px[23 - 8*k -: 8];
            pos = int'(cfg_col_off) + lmsp_pkg::COLORS*c + k;
            if (pos < LINE_BITS) line[pos] = (comp >= depth_ctr);
          end
        end
        for (int b = 0; b < LINE_BYTES; b++) begin
          rec.line_byte    = line[8*b +: 8];
          rec.byte_index   = b[5:0];
          rec.scan_row     = scan_row_ctr;
          rec.depth_step   = depth_ctr;
          rec.last_of_line = (b == LINE_BYTES - 1);
          rec.swap_pending = swap_flag;
          expected_bytes.push_back(rec);
        end
        // Advance depth, then row, and swap at the end of the frame
        limit = (cfg_depth == 0) ? 8'd1 : cfg_depth;
        if (depth_ctr >= limit) begin
          depth_ctr = 8'd1;
          if (scan_row_ctr == ROWS - 1) begin
            scan_row_ctr = '0;
            if (swap_flag) begin
              front_sel = ~front_sel;
              swap_flag = 1'b0;
            end
          end else begin
            scan_row_ctr++;
          end
        end else begin
          depth_ctr++;
        end
      end
      default: ;
    endcase
  endfunction

  // Check each line byte against the oldest prediction
  always @(posedge clk) begin
    line_byte_t got;
    line_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[13:8], m_tdata[16:14], m_tdata[24:17], m_tlast,
             m_tdata[25]};
      if (expected_bytes.size() == 0) begin
        log_failure({"unexpected line byte: ", fmt_line_byte(got)});
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          log_failure({"line byte mismatch: expected ", fmt_line_byte(want),
                       " got ", fmt_line_byte(got)});
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 24) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pixel_word(logic [2:0] row, logic [2:0] col,
                                             logic [7:0] red, logic [7:0] green,
                                             logic [7:0] blue);
    return {2'b00, blue, green, red, col, row};
  endfunction

  // Bias components toward the ends and the low depth steps
  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 4));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic [1:0] op, logic [31:0] data);
    if (tx_idle_on && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    apply_scan_item(op, data);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_item(lmsp_pkg::OP_WRITE,
                pixel_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           rand_level(), rand_level(), rand_level()));
    else if (pick < 87)
      send_item(lmsp_pkg::OP_TICK, $urandom & PAD_MASK);
    else if (pick < 95)
      send_item(lmsp_pkg::OP_SWAP, $urandom & PAD_MASK);
    else
      send_item(OP_UNUSED, $urandom & PAD_MASK);
  endtask

  // Drop valid, drain all predicted bytes, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(lmsp_pkg::cfg_reg_t idx,
                                logic [lmsp_pkg::CFG_DAT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      lmsp_pkg::CFG_COLOR_DEPTH: cfg_depth   = value[lmsp_pkg::DEPTH_W-1:0];
      lmsp_pkg::CFG_COL_OFFSET:  cfg_col_off = value[lmsp_pkg::OFFSET_W-1:0];
      lmsp_pkg::CFG_ROW_OFFSET:  cfg_row_off = value[lmsp_pkg::OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_registers(logic [7:0] depth, logic [8:0] col_off,
                                   logic [8:0] row_off);
    write_register(lmsp_pkg::CFG_COLOR_DEPTH, {1'b0, depth});
    write_register(lmsp_pkg::CFG_COL_OFFSET, col_off);
    write_register(lmsp_pkg::CFG_ROW_OFFSET, row_off);
  endtask

  // Scan a black frame with the reset register values
  task automatic test_reset_scan();
    repeat (3) send_item(lmsp_pkg::OP_TICK, '0);
    wait_idle();
  endtask

  // Write four pixels to the back frame, request a swap and scan through the
  // frame boundary; shrinking the depth mid-row also forces an early row advance
  task automatic test_frame_swap();
    program_registers(8'd1, 9'd0, 9'd24);
    send_item(lmsp_pkg::OP_WRITE, pixel_word(3'd0, 3'd0, 8'd255, 8'd255, 8'd255));
    send_item(lmsp_pkg::OP_WRITE, pixel_word(3'd0, 3'd7, 8'd1, 8'd0, 8'd255));
    send_item(lmsp_pkg::OP_WRITE, pixel_word(3'd7, 3'd3, 8'd128, 8'd64, 8'd2));
    send_item(lmsp_pkg::OP_WRITE, pixel_word(3'd1, 3'd5, 8'd0, 8'd255, 8'd0));
    send_item(OP_UNUSED, $urandom & PAD_MASK);
    send_item(lmsp_pkg::OP_SWAP, '0);
    repeat (10) send_item(lmsp_pkg::OP_TICK, '0);
    wait_idle();
  endtask

  // Offsets at the extremes: dropped bits, overlap and zero depth
  task automatic test_line_offsets();
    program_registers(8'd0, 9'd511, 9'd511);
    send_item(lmsp_pkg::OP_TICK, '0);
    wait_idle();
    program_registers(8'd1, 9'd0, 9'd0);
    send_item(lmsp_pkg::OP_TICK, '0);
    wait_idle();
    program_registers(8'd1, 9'd9, 9'd31);
    repeat (2) send_item(lmsp_pkg::OP_TICK, '0);
    wait_idle();
  endtask

  task automatic test_random_traffic(int unsigned count, logic [7:0] depth,
                                     logic [8:0] col_off, logic [8:0] row_off,
                                     bit with_idling);
    program_registers(depth, col_off, row_off);
    tx_idle_on = with_idling;
    rx_idle_on <= with_idling;
    repeat (count) send_random_item();
    wait_idle();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // Hold off the receiver while ticks keep coming, so the input stalls
  task automatic test_output_backpressure();
    program_registers(8'd1, 9'd5, 9'd0);
    hold_req <= hold_req + 1;
    repeat (12) send_item(lmsp_pkg::OP_TICK, '0);
    repeat (30) send_random_item();
    wait_idle();
  endtask

  initial begin
    reset_scan_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_scan();
    test_frame_swap();
    test_line_offsets();
    test_random_traffic(45, 8'd2, 9'd0, 9'd24, 1'b1);
    test_random_traffic(40, 8'd3, 9'($urandom_range(0, 40)), 9'($urandom_range(0, 40)),
                        1'b1);
    test_random_traffic(30, 8'd255, 9'd0, 9'd24, 1'b1);
    test_output_backpressure();
    test_random_traffic(55, 8'd1, 9'($urandom_range(0, 16)), 9'($urandom_range(16, 40)),
                        1'b0);
    test_random_traffic(30, 8'd4, 9'd2, 9'd26, 1'b1);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lmsp_pkg.sv
rtl/led_matrix_scan_pwm.sv
tb/sv/tb_led_matrix_scan_pwm.sv
